// ===== hw/rtl/spq_pkg.sv =====
// shared types, codes and sizes of the stable priority task queue
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PRIO_W          = 8;
	localparam int HANDLE_W        = 16;
	localparam int STATUS_W        = 2;
	localparam int OCC_W           = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} spq_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic                ins;
		logic                pop;
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
	} spq_ctl_t;

endpackage

// ===== hw/rtl/spq_req_if.sv =====
// request channel: insert or pop command with task payload
interface spq_req_if;
	import spq_pkg::*;

	logic                valid;
	logic                ready;
	logic                opcode;
	logic [PRIO_W-1:0]   task_priority;
	logic [HANDLE_W-1:0] task_handle;

	modport source (output valid, output opcode, output task_priority, output task_handle,
		input ready);
	modport sink (input valid, input opcode, input task_priority, input task_handle,
		output ready);
endinterface

// ===== hw/rtl/spq_rsp_if.sv =====
// result channel: status, popped task and occupancy
interface spq_rsp_if;
	import spq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] popped_handle;
	logic [PRIO_W-1:0]   popped_priority;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output popped_handle,
		output popped_priority, output occupancy, input ready);
	modport sink (input valid, input status, input popped_handle,
		input popped_priority, input occupancy, output ready);
endinterface

// ===== hw/rtl/spq_cell.sv =====
// one slot of the sorted row: holds a task and trades it with its neighbors
module spq_cell (
	input  logic                        clk,
	input  spq_pkg::spq_ctl_t           ctl,
	input  logic                        occupied,
	input  logic                        at_tail,
	input  logic                        left_move,
	input  logic [spq_pkg::PRIO_W-1:0]   left_prio,
	input  logic [spq_pkg::HANDLE_W-1:0] left_handle,
	input  logic [spq_pkg::PRIO_W-1:0]   right_prio,
	input  logic [spq_pkg::HANDLE_W-1:0] right_handle,
	output logic [spq_pkg::PRIO_W-1:0]   prio,
	output logic [spq_pkg::HANDLE_W-1:0] handle,
	output logic                        move
);
	import spq_pkg::*;

	logic [PRIO_W-1:0]   prio_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [PRIO_W-1:0]   prio_d;
	logic [HANDLE_W-1:0] handle_d;

	// stored task is less urgent than the new one, so it steps one slot back
	assign move   = occupied && (prio_q > ctl.prio);
	assign prio   = prio_q;
	assign handle = handle_q;

	// pick the left neighbor, the new task, the right neighbor or hold
	always_comb begin
		prio_d   = prio_q;
		handle_d = handle_q;
		if (ctl.ins) begin
			if (left_move) begin
				prio_d   = left_prio;
				handle_d = left_handle;
			end else if (move || at_tail) begin
				prio_d   = ctl.prio;
				handle_d = ctl.handle;
			end
		end else if (ctl.pop) begin
			prio_d   = right_prio;
			handle_d = right_handle;
		end
	end

	// task storage
	always_ff @(posedge clk) begin
		prio_q   <= prio_d;
		handle_q <= handle_d;
	end
endmodule

// ===== hw/rtl/stable_priority_task_queue.sv =====
// top level: row of queue cells, entry count and registered result
//
//  channel | dir | fields                                               | accepted when
//  req     | in  | opcode, task_priority, task_handle                   | valid && ready
//  rsp     | out | status, popped_handle, popped_priority, occupancy    | valid && ready
//
// all cells compare against the new priority at once and shift in the same edge,
// so a request can be taken in every cycle while the result side keeps up.
// the result is registered; req.ready stays high while that register is empty or is
// being taken, so a stalled result holds off only the following request.
// reset clears the entry count and the result valid; cell contents are not reset.
module stable_priority_task_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                rsp_valid_q;
	spq_status_t         status_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [OCC_W-1:0]    occ_q;

	logic accept;
	logic full;
	logic empty;
	logic is_pop;
	spq_ctl_t ctl;

	logic [PRIO_W-1:0]   cell_prio   [QUEUE_DEPTH];
	logic [HANDLE_W-1:0] cell_handle [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_move;
	logic [QUEUE_DEPTH-1:0] cell_occ;
	logic [QUEUE_DEPTH-1:0] cell_tail;

	// handshake and queue status
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign is_pop    = (req.opcode == OP_POP);

	// command to the cells
	always_comb begin
		ctl.ins    = accept && !is_pop && !full;
		ctl.pop    = accept && is_pop && !empty;
		ctl.prio   = req.task_priority;
		ctl.handle = req.task_handle;
	end

	// row of cells, head at index zero
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign cell_occ[i]  = (CNT_W'(i) < count_q);
		assign cell_tail[i] = (CNT_W'(i) == count_q);

		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.occupied     (cell_occ[i]),
				.at_tail      (cell_tail[i]),
				.left_move    (1'b0),
				.left_prio    ('0),
				.left_handle  ('0),
				.right_prio   (cell_prio[i+1]),
				.right_handle (cell_handle[i+1]),
				.prio         (cell_prio[i]),
				.handle       (cell_handle[i]),
				.move         (cell_move[i])
			);
		end else if (i == QUEUE_DEPTH - 1) begin : g_last
			spq_cell u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.occupied     (cell_occ[i]),
				.at_tail      (cell_tail[i]),
				.left_move    (cell_move[i-1]),
				.left_prio    (cell_prio[i-1]),
				.left_handle  (cell_handle[i-1]),
				.right_prio   (cell_prio[i]),
				.right_handle (cell_handle[i]),
				.prio         (cell_prio[i]),
				.handle       (cell_handle[i]),
				.move         (cell_move[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.occupied     (cell_occ[i]),
				.at_tail      (cell_tail[i]),
				.left_move    (cell_move[i-1]),
				.left_prio    (cell_prio[i-1]),
				.left_handle  (cell_handle[i-1]),
				.right_prio   (cell_prio[i+1]),
				.right_handle (cell_handle[i+1]),
				.prio         (cell_prio[i]),
				.handle       (cell_handle[i]),
				.move         (cell_move[i])
			);
		end
	end

	// next entry count
	always_comb begin
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			occ_q <= OCC_W'(count_d);
			if (!is_pop) begin
				status_q <= full ? ST_FULL : ST_OK;
				handle_q <= '0;
				prio_q   <= '0;
			end else if (empty) begin
				status_q <= ST_EMPTY;
				handle_q <= '0;
				prio_q   <= '0;
			end else begin
				status_q <= ST_OK;
				handle_q <= cell_handle[0];
				prio_q   <= cell_prio[0];
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.popped_handle   = handle_q;
	assign rsp.popped_priority = prio_q;
	assign rsp.occupancy       = occ_q;

	// count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	// a dropped insert leaves the count alone
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_pop && full |=> $stable(count_q))
		else $error("count changed on dropped insert");

	// a pop on a filled queue reports ok
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_pop && !empty |=> rsp.valid && rsp.status == ST_OK)
		else $error("pop on filled queue not reported ok");

	// the two front entries stay in order
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_prio[0] <= cell_prio[1])
		else $error("head entries out of order");
endmodule

// ===== tb/sv/stable_priority_task_queue_test.sv =====
// testbench for the stable priority task queue: directed and random insert/pop traffic
`timescale 1ns / 100ps

module stable_priority_task_queue_test;
	import spq_pkg::*;

	localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		spq_status_t         status;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
		logic [OCC_W-1:0]    occ;
		logic                popped;
	} queue_result_t;

	logic clk;
	logic arst_n;

	spq_req_if req ();
	spq_rsp_if rsp ();

	stable_priority_task_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	// shadow copy of the queue contents, head at index 0
	logic [PRIO_W-1:0]   shadow_prio [QUEUE_DEPTH];
	logic [HANDLE_W-1:0] shadow_handle [QUEUE_DEPTH];
	int                  shadow_len;

	queue_result_t pending_results[$];

	int req_idle_pct = 17;
	int rsp_stall_pct = 17;
	int error_count = 0;
	int cycle_count = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int drops_seen = 0;
	int empty_pops_seen = 0;
	int tasks_popped = 0;
	int peak_occupancy = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// expected result of one request, updating the shadow queue
	function automatic queue_result_t predict_queue_result(spq_op_t op,
		logic [PRIO_W-1:0] prio, logic [HANDLE_W-1:0] handle);
		queue_result_t r;
		int pos;
		r.status = ST_OK;
		r.handle = '0;
		r.prio = '0;
		r.popped = 1'b0;
		if (op == OP_INSERT) begin
			if (shadow_len >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// land behind every entry of equal or lower value
				pos = 0;
				while (pos < shadow_len && shadow_prio[pos] <= prio)
					pos++;
				for (int i = shadow_len; i > pos; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_handle[i] = shadow_handle[i-1];
				end
				shadow_prio[pos] = prio;
				shadow_handle[pos] = handle;
				shadow_len++;
			end
		end else if (shadow_len == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.handle = shadow_handle[0];
			r.prio = shadow_prio[0];
			r.popped = 1'b1;
			for (int i = 1; i < shadow_len; i++) begin
				shadow_prio[i-1] = shadow_prio[i];
				shadow_handle[i-1] = shadow_handle[i];
			end
			shadow_len--;
		end
		r.occ = OCC_W'(shadow_len);
		return r;
	endfunction

	// one request: random idle gap, then hold until accepted
	task automatic send_request(spq_op_t op, logic [PRIO_W-1:0] prio,
		logic [HANDLE_W-1:0] handle);
		while ($urandom_range(99) < req_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.task_priority <= prio;
		req.task_handle <= handle;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pending_results.push_back(predict_queue_result(op, prio, handle));
		requests_sent++;
		if (shadow_len > peak_occupancy)
			peak_occupancy = shadow_len;
	endtask

	task automatic send_insert(logic [PRIO_W-1:0] prio, logic [HANDLE_W-1:0] handle);
		send_request(OP_INSERT, prio, handle);
	endtask

	// pop with junk in the ignored payload fields
	task automatic send_pop();
		send_request(OP_POP, PRIO_W'($urandom), HANDLE_W'($urandom));
	endtask

	// result stall driver and checker
	initial begin
		queue_result_t want;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: status %0d", rsp.status);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						error_count++;
					end
					if (rsp.popped_handle !== want.handle) begin
						$error("popped_handle: expected %0h, actual %0h", want.handle,
							rsp.popped_handle);
						error_count++;
					end
					if (rsp.popped_priority !== want.prio) begin
						$error("popped_priority: expected %0d, actual %0d", want.prio,
							rsp.popped_priority);
						error_count++;
					end
					if (rsp.occupancy !== want.occ) begin
						$error("occupancy: expected %0d, actual %0d", want.occ,
							rsp.occupancy);
						error_count++;
					end
					case (want.status)
						ST_FULL: drops_seen++;
						ST_EMPTY: empty_pops_seen++;
						default: if (want.popped) tasks_popped++;
					endcase
				end
			end
			rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	// pops on an empty queue, payload at both extremes
	task automatic test_empty_pops();
		send_request(OP_POP, '0, '0);
		send_request(OP_POP, '1, '1);
	endtask

	// field extremes and equal priorities leaving in arrival order
	task automatic test_extremes_and_ties();
		send_insert(8'hFF, 16'hFFFF);
		send_insert(8'h00, 16'h0000);
		send_insert(8'hFF, 16'h1234);
		send_insert(8'h00, 16'hFFFF);
		send_insert(8'h80, 16'h8000);
		send_insert(8'h7F, 16'h7FFF);
		repeat (7)
			send_pop();
	endtask

	// fill to the top, push past it, then drain past empty
	task automatic test_full_queue();
		while (shadow_len < QUEUE_DEPTH)
			send_insert(PRIO_W'($urandom_range(3)), HANDLE_W'($urandom));
		repeat (3)
			send_insert(PRIO_W'($urandom), HANDLE_W'($urandom));
		send_pop();
		send_insert(8'h00, HANDLE_W'($urandom));
		send_insert(8'hFF, HANDLE_W'($urandom));
		while (shadow_len > 0)
			send_pop();
		send_pop();
	endtask

	// phases of insert-heavy, pop-heavy and balanced traffic
	task automatic test_random_traffic(int n);
		int left;
		int phase_len;
		int insert_pct;
		int prio_hi;
		left = n;
		while (left > 0) begin
			phase_len = $urandom_range(80, 20);
			if (phase_len > left)
				phase_len = left;
			case ($urandom_range(2))
				0: insert_pct = 85;
				1: insert_pct = 20;
				default: insert_pct = 55;
			endcase
			// narrow priority ranges make plenty of ties
			case ($urandom_range(2))
				0: prio_hi = 3;
				1: prio_hi = 15;
				default: prio_hi = 255;
			endcase
			repeat (phase_len) begin
				if ($urandom_range(99) < insert_pct)
					send_insert(PRIO_W'($urandom_range(prio_hi)), HANDLE_W'($urandom));
				else
					send_pop();
			end
			left -= phase_len;
		end
	endtask

	// back-to-back requests with the result side always ready
	task automatic test_no_idle_burst();
		req_idle_pct = 0;
		rsp_stall_pct = 0;
		test_random_traffic(150);
		req_idle_pct = 17;
		rsp_stall_pct = 17;
	endtask

	// sequence of tests
	initial begin
		req.valid <= 1'b0;
		req.opcode <= OP_INSERT;
		req.task_priority <= '0;
		req.task_handle <= '0;
		shadow_len = 0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_extremes_and_ties();
		test_full_queue();
		test_random_traffic(400);
		test_no_idle_burst();
		test_full_queue();
		test_random_traffic(400);
		req.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d requests, checked %0d results, peak occupancy %0d",
			requests_sent, results_seen, peak_occupancy);
		$display("tasks popped %0d, inserts dropped when full %0d, pops on empty %0d",
			tasks_popped, drops_seen, empty_pops_seen);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", error_count);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
